>>> sv/canrxf_pkg.sv
// Package with the item types, codes and constants of the CAN receive ID-list filter and queue.
`default_nettype none

package canrxf_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int LIST_SIZE_DEF   = 32;

    localparam logic [3:0] CLASSIC_MAX_LEN = 4'd8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_EXT   = 1'b1;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_FRAME = 2'd1,
        FN_POP   = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_FILTERED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_TOO_SMALL = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [4:0]  entry_index;
        logic [28:0] frame_id;
        logic        frame_ide;
        logic        frame_rtr;
        logic        frame_fdf;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
        logic [3:0]  pop_capacity;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [28:0] out_id;
        logic        out_ide;
        logic        out_rtr;
        logic [3:0]  out_dlc;
        logic [3:0]  out_length;
        logic [63:0] out_data;
        logic [31:0] full_drop_count;
        logic [31:0] filter_drop_count;
        logic [31:0] malformed_count;
        logic [3:0]  queue_space;
    } t_out_item;

    // One receive queue entry: frame header and payload side by side.
    typedef struct packed {
        logic [28:0] id;
        logic        ide;
        logic        rtr;
        logic [3:0]  dlc;
        logic [63:0] data;
    } t_qentry;

    // Keeps the low len bytes of a payload and clears the rest.
    function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] len);
        logic [63:0] kept;
        kept = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                kept[b*8 +: 8] = data[b*8 +: 8];
            end
        end
        return kept;
    endfunction

endpackage

`default_nettype wire

>>> sv/can_rx_id_list_filter_fifo_core.sv
// Top level of the classic-CAN receive path with ID-list acceptance filter and receive queue.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in   (canrxf_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready o_out  (canrxf_pkg::t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One input transaction is worked on at a time; it is taken in S_IDLE and then walks the
// states. A load, an empty pop, a malformed frame, a frame in the wrong format or a frame
// with the list off goes through S_EVAL and S_DONE into the output register; a pop that
// returns a frame goes through S_EVAL, S_POP and S_DONE. A frame checked against the list
// walks S_SCAN over up to n entries one by one, n being list_count clamped to the list size,
// since the ID-list memory has one read port and the walk reads one entry per cycle,
// stopping at the first hit, and then goes to S_DONE.
// The output register lets the next input transaction be accepted while a result still
// waits; a result that finds the register occupied waits in place, stalling the input.
// Reset is synchronous and active low; it clears the queue pointers, fill level, drop
// counters and configuration. The list and queue memories hold garbage until written.

module can_rx_id_list_filter_fifo_core #(
    parameter int QUEUE_DEPTH = canrxf_pkg::QUEUE_DEPTH_DEF,
    parameter int LIST_SIZE   = canrxf_pkg::LIST_SIZE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire canrxf_pkg::t_in_item             i_in,

    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output canrxf_pkg::t_out_item                 o_out,

    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [canrxf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [canrxf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import canrxf_pkg::*;

    // Widths derived from the memory sizes.
    localparam int LW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;    // list address
    localparam int CW = $clog2(LIST_SIZE + 1);                      // list walk counter
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1; // queue pointer
    localparam int FW = $clog2(QUEUE_DEPTH + 1);                    // queue fill level

    // Configuration registers.
    logic [5:0]    r_list_count;
    logic          r_list_ext;

    // Control state.
    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [31:0]   r_full, n_full;
    logic [31:0]   r_filt, n_filt;
    logic [31:0]   r_malf, n_malf;
    logic          r_cmp_valid, n_cmp_valid;

    // Payload registers.
    t_in_item      r_item, n_item;
    t_out_item     r_res, n_res;
    t_out_item     r_out, n_out;
    logic [CW-1:0] r_scan_addr, n_scan_addr;

    // Memories and their registered read data.
    logic [28:0]   list_mem [LIST_SIZE];
    t_qentry       q_mem [QUEUE_DEPTH];
    logic [28:0]   r_list_q;
    t_qentry       r_q_q;

    logic          w_list_we;
    logic          w_list_re;
    logic          w_q_we;
    logic          w_enq;
    logic          w_filtered;
    logic          w_idx_ok;
    logic          w_list_active;
    logic          w_malformed;
    logic [6:0]    w_count_ext;
    logic [CW-1:0] w_scan_n;
    logic [3:0]    w_len;
    logic [3:0]    w_cap;
    t_qentry       w_q_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // A list_count above the list size walks the whole list.
    assign w_count_ext   = {1'b0, r_list_count};
    assign w_scan_n      = (w_count_ext > 7'(LIST_SIZE)) ? CW'(LIST_SIZE) : CW'(w_count_ext);
    assign w_list_active = (r_list_count != 6'd0);
    assign w_idx_ok      = (7'(r_item.entry_index) < 7'(LIST_SIZE));
    assign w_malformed   = r_item.frame_fdf || (r_item.frame_dlc > CLASSIC_MAX_LEN);

    // Payload length of the frame at the queue head and the caller's saturated capacity.
    assign w_len = r_q_q.rtr ? 4'd0 :
                   ((r_q_q.dlc > CLASSIC_MAX_LEN) ? CLASSIC_MAX_LEN : r_q_q.dlc);
    assign w_cap = (r_item.pop_capacity > CLASSIC_MAX_LEN) ? CLASSIC_MAX_LEN :
                   r_item.pop_capacity;

    assign w_q_wdata = '{id:   r_item.frame_id,
                         ide:  r_item.frame_ide,
                         rtr:  r_item.frame_rtr,
                         dlc:  r_item.frame_dlc,
                         data: r_item.frame_data};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_full      = r_full;
        n_filt      = r_filt;
        n_malf      = r_malf;
        n_cmp_valid = r_cmp_valid;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_scan_addr = r_scan_addr;
        w_list_we   = 1'b0;
        w_list_re   = 1'b0;
        w_q_we      = 1'b0;
        w_enq       = 1'b0;
        w_filtered  = 1'b0;

        // The output register empties when its transaction is taken.
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res        = '0;
                n_res.status = ST_OK;
                n_state      = S_DONE;
                case (r_item.func)
                    FN_LOAD: begin
                        w_list_we = w_idx_ok;
                    end
                    FN_FRAME: begin
                        if (w_malformed) begin
                            n_malf       = r_malf + 32'd1;
                            n_res.status = ST_MALFORMED;
                        end else if (w_list_active && (r_item.frame_ide != r_list_ext)) begin
                            w_filtered = 1'b1;
                        end else if (w_list_active) begin
                            n_scan_addr = '0;
                            n_cmp_valid = 1'b0;
                            n_state     = S_SCAN;
                        end else begin
                            w_enq = 1'b1;
                        end
                    end
                    FN_POP: begin
                        if (r_fill == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_POP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // Reads go out one per cycle; each compare sees the entry read the cycle before.
                w_list_re   = (r_scan_addr < w_scan_n);
                n_scan_addr = r_scan_addr + CW'(w_list_re);
                n_cmp_valid = w_list_re;
                if (r_cmp_valid && (r_list_q == r_item.frame_id)) begin
                    w_enq   = 1'b1;
                    n_state = S_DONE;
                end else if (!r_cmp_valid && !w_list_re) begin
                    w_filtered = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_POP: begin
                n_res.out_id     = r_q_q.id;
                n_res.out_ide    = r_q_q.ide;
                n_res.out_rtr    = r_q_q.rtr;
                n_res.out_dlc    = r_q_q.dlc;
                n_res.out_length = w_len;
                if (w_len > w_cap) begin
                    n_res.status   = ST_TOO_SMALL;
                    n_res.out_data = '0;
                end else begin
                    n_res.out_data = keep_bytes(r_q_q.data, w_len);
                end
                n_head  = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
                n_fill  = r_fill - FW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out                   = r_res;
                    n_out.full_drop_count   = r_full;
                    n_out.filter_drop_count = r_filt;
                    n_out.malformed_count   = r_malf;
                    n_out.queue_space       = 4'(FW'(QUEUE_DEPTH) - r_fill);
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_filtered) begin
            n_filt       = r_filt + 32'd1;
            n_res.status = ST_FILTERED;
        end

        if (w_enq) begin
            if (r_fill == FW'(QUEUE_DEPTH)) begin
                n_full       = r_full + 32'd1;
                n_res.status = ST_FULL;
            end else begin
                w_q_we = 1'b1;
                n_tail = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);
                n_fill = r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_full       <= '0;
            r_filt       <= '0;
            r_malf       <= '0;
            r_cmp_valid  <= 1'b0;
            r_list_count <= '0;
            r_list_ext   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_full      <= n_full;
            r_filt      <= n_filt;
            r_malf      <= n_malf;
            r_cmp_valid <= n_cmp_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LIST_COUNT: r_list_count <= i_cfg_data;
                    CFG_LIST_EXT:   r_list_ext   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_res       <= n_res;
        r_out       <= n_out;
        r_scan_addr <= n_scan_addr;
    end

    // ID-list memory: written by loads, read by the list walk; never both at once.
    always_ff @(posedge i_clk) begin
        if (w_list_we) begin
            list_mem[LW'(r_item.entry_index)] <= r_item.frame_id;
        end
        if (w_list_re) begin
            r_list_q <= list_mem[r_scan_addr[LW-1:0]];
        end
    end

    // Receive queue memory: written at the tail, read at the head every cycle.
    // A pop reads the head only after any write has passed through S_DONE and S_IDLE, so the data is current.
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            q_mem[r_tail] <= w_q_wdata;
        end
        r_q_q <= q_mem[r_head];
    end

endmodule

`default_nettype wire

>>> sv/canrxf_checker.sv
// Port checker for the CAN receive ID-list filter and queue, with its bind statement.
`default_nettype none

module canrxf_checker #(
    parameter int QUEUE_DEPTH = canrxf_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire canrxf_pkg::t_in_item              i_in,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire canrxf_pkg::t_out_item             o_out,
    input wire logic                              i_cfg_valid,
    input wire logic                              o_cfg_ready,
    input wire logic [canrxf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [canrxf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import canrxf_pkg::*;

    // A waiting result transaction stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result transaction changed or vanished while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A pop into too small a buffer reports no payload.
    a_too_small_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_TOO_SMALL) |-> (o_out.out_data == 64'd0))
        else $error("payload reported for a too-small pop");

    // An empty pop sees the whole queue free.
    a_empty_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_EMPTY) |-> (o_out.queue_space == 4'(QUEUE_DEPTH)))
        else $error("empty pop with queue space below depth");

    // A full drop sees no free queue entry.
    a_full_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_FULL) |-> (o_out.queue_space == 4'(0)))
        else $error("full drop reported with free queue space");

endmodule

bind can_rx_id_list_filter_fifo_core canrxf_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_canrxf_checker (.*);

`default_nettype wire
